### sv/b64d_pkg.sv
`default_nettype none
package b64d_pkg;

  // Depth of the queue between the classifier and the bit packer.
  localparam int unsigned QDEPTH = 2;
  localparam int unsigned QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

  typedef enum logic [1:0] {
    CLS_DATA = 2'd0,
    CLS_PAD  = 2'd1,
    CLS_BAD  = 2'd2
  } char_class_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_BADCHAR = 2'd1,
    ST_PADDING = 2'd2,
    ST_LENGTH  = 2'd3
  } status_e;

  typedef struct packed {
    logic [7:0] text_char;
    logic       last_char;
  } in_req_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       done_res;
    logic [1:0] status;
  } out_req_t;

  // One classified character as it travels through the queue.
  typedef struct packed {
    char_class_e kind;
    logic [5:0]  sextet;
    logic        last;
  } item_t;

endpackage
`default_nettype wire

### sv/base64_decoder_top.sv
// Streaming base64 decoder, one character per request, one result per request.
// Each request passes through the queue and then into the packer's output register;
// throughput is one request per cycle while the consumer takes the results.
// The figure is set by the bit packer, which updates its small state once per character.
// Reset (rst_ni low, asynchronous) empties the queue and the output register and
// clears the residual bits, position, padding count and error latch.
`default_nettype none
module base64_decoder_top (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 in_valid_i,
  output logic                in_ready_o,
  input  b64d_pkg::in_req_t   in_req_i,
  output logic                out_valid_o,
  input  wire                 out_ready_i,
  output b64d_pkg::out_req_t  out_req_o
);

  // The classifier turns each character into a class and a sextet. It only
  // stalls when the queue is full, so it never waits on the consumer directly.
  logic            push;
  logic            full;
  b64d_pkg::item_t front_item;

  // The queue decouples the classifier from the packer, so a stalled consumer
  // does not hold back the producer until the queue has filled.
  logic            q_valid;
  logic            pop;
  b64d_pkg::item_t q_item;

  b64d_front u_front (
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_req_i   (in_req_i),
    .full_i     (full),
    .push_o     (push),
    .item_o     (front_item)
  );

  b64d_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (front_item),
    .full_o  (full),
    .valid_o (q_valid),
    .pop_i   (pop),
    .item_o  (q_item)
  );

  // The packer keeps the residual bits, checks padding and length, latches the
  // first error, and holds each result in an output register until taken.
  b64d_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (q_valid),
    .item_i      (q_item),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_req_o   (out_req_o)
  );

endmodule
`default_nettype wire

### sv/b64d_front.sv
`default_nettype none
module b64d_front (
  input  wire                 in_valid_i,
  output logic                in_ready_o,
  input  b64d_pkg::in_req_t   in_req_i,
  input  wire                 full_i,
  output logic                push_o,
  output b64d_pkg::item_t     item_o
);

  logic [7:0] c;

  assign c          = in_req_i.text_char;
  assign in_ready_o = !full_i;
  assign push_o     = in_valid_i && !full_i;

  // Map the character onto its class and, for alphabet members, its sextet.
  always_comb begin
    item_o.last   = in_req_i.last_char;
    item_o.kind   = b64d_pkg::CLS_BAD;
    item_o.sextet = 6'd0;
    if (c >= 8'h41 && c <= 8'h5A) begin
      item_o.kind   = b64d_pkg::CLS_DATA;
      item_o.sextet = 6'(c - 8'h41);
    end else if (c >= 8'h61 && c <= 8'h7A) begin
      item_o.kind   = b64d_pkg::CLS_DATA;
      item_o.sextet = 6'(c - 8'h61 + 8'd26);
    end else if (c >= 8'h30 && c <= 8'h39) begin
      item_o.kind   = b64d_pkg::CLS_DATA;
      item_o.sextet = 6'(c - 8'h30 + 8'd52);
    end else if (c == 8'h2B) begin
      item_o.kind   = b64d_pkg::CLS_DATA;
      item_o.sextet = 6'd62;
    end else if (c == 8'h2F) begin
      item_o.kind   = b64d_pkg::CLS_DATA;
      item_o.sextet = 6'd63;
    end else if (c == 8'h3D) begin
      item_o.kind   = b64d_pkg::CLS_PAD;
    end
  end

endmodule
`default_nettype wire

### sv/b64d_queue.sv
`default_nettype none
module b64d_queue (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 push_i,
  input  b64d_pkg::item_t     item_i,
  output logic                full_o,
  output logic                valid_o,
  input  wire                 pop_i,
  output b64d_pkg::item_t     item_o
);

  b64d_pkg::item_t                 mem_q [b64d_pkg::QDEPTH];
  logic [b64d_pkg::QPTR_W-1:0]     wr_ptr_q, wr_ptr_d;
  logic [b64d_pkg::QPTR_W-1:0]     rd_ptr_q, rd_ptr_d;
  logic [b64d_pkg::QCNT_W-1:0]     cnt_q, cnt_d;

  assign full_o  = (cnt_q == b64d_pkg::QCNT_W'(b64d_pkg::QDEPTH));
  assign valid_o = (cnt_q != '0);
  assign item_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == b64d_pkg::QPTR_W'(b64d_pkg::QDEPTH - 1)) ? '0
               : wr_ptr_q + b64d_pkg::QPTR_W'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == b64d_pkg::QPTR_W'(b64d_pkg::QDEPTH - 1)) ? '0
               : rd_ptr_q + b64d_pkg::QPTR_W'(1);
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + b64d_pkg::QCNT_W'(1);
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - b64d_pkg::QCNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o)
    else $error("queue written while full");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> valid_o)
    else $error("queue read while empty");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= b64d_pkg::QCNT_W'(b64d_pkg::QDEPTH))
    else $error("queue count beyond depth");

endmodule
`default_nettype wire

### sv/b64d_back.sv
`default_nettype none
module b64d_back (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 valid_i,
  input  b64d_pkg::item_t     item_i,
  output logic                pop_o,
  output logic                out_valid_o,
  input  wire                 out_ready_i,
  output b64d_pkg::out_req_t  out_req_o
);

  logic [5:0]           bits_q, bits_d;
  logic [2:0]           cnt_q, cnt_d;
  logic [1:0]           pos_q, pos_d;
  logic [1:0]           pad_q, pad_d;
  b64d_pkg::status_e    err_q, err_d;
  logic                 out_valid_q;
  b64d_pkg::out_req_t   out_q, out_d;
  logic                 fire;
  logic [11:0]          acc;
  logic [3:0]           sum;
  logic [3:0]           rem;
  logic [11:0]          shifted;

  // The output register takes a new result whenever it is empty or drained.
  assign fire        = valid_i && (!out_valid_q || out_ready_i);
  assign pop_o       = fire;
  assign out_valid_o = out_valid_q;
  assign out_req_o   = out_q;

  assign acc     = {bits_q, item_i.sextet};
  assign sum     = {1'b0, cnt_q} + 4'd6;
  assign rem     = (sum >= 4'd8) ? sum - 4'd8 : sum;
  assign shifted = acc >> rem;

  always_comb begin
    bits_d           = bits_q;
    cnt_d            = cnt_q;
    pad_d            = pad_q;
    err_d            = err_q;
    out_d.out_byte   = 8'd0;
    out_d.byte_valid = 1'b0;
    out_d.done_res   = item_i.last;
    out_d.status     = b64d_pkg::ST_OK;
    if (item_i.kind == b64d_pkg::CLS_PAD) begin
      if (pad_q >= 2'd2) begin
        if (err_q == b64d_pkg::ST_OK) err_d = b64d_pkg::ST_PADDING;
      end else begin
        pad_d = pad_q + 2'd1;
      end
    end else if (pad_q != 2'd0) begin
      if (err_q == b64d_pkg::ST_OK) err_d = b64d_pkg::ST_PADDING;
    end else if (item_i.kind == b64d_pkg::CLS_BAD) begin
      if (err_q == b64d_pkg::ST_OK) err_d = b64d_pkg::ST_BADCHAR;
    end else if (err_q == b64d_pkg::ST_OK) begin
      if (sum >= 4'd8) begin
        out_d.out_byte   = shifted[7:0];
        out_d.byte_valid = 1'b1;
      end
      bits_d = acc[5:0] & 6'((7'd1 << rem[2:0]) - 7'd1);
      cnt_d  = rem[2:0];
    end
    pos_d = pos_q + 2'd1;
    if (item_i.last) begin
      out_d.status = (pos_d != 2'd0) ? b64d_pkg::ST_LENGTH : err_d;
      bits_d = '0;
      cnt_d  = '0;
      pos_d  = '0;
      pad_d  = '0;
      err_d  = b64d_pkg::ST_OK;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bits_q      <= '0;
      cnt_q       <= '0;
      pos_q       <= '0;
      pad_q       <= '0;
      err_q       <= b64d_pkg::ST_OK;
      out_valid_q <= 1'b0;
    end else begin
      if (fire) begin
        bits_q <= bits_d;
        cnt_q  <= cnt_d;
        pos_q  <= pos_d;
        pad_q  <= pad_d;
        err_q  <= err_d;
      end
      if (fire) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_q <= out_d;
    end
  end

  a_byte_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && out_d.byte_valid |-> (err_q == b64d_pkg::ST_OK) && (pad_q == 2'd0))
    else $error("byte produced after an error or padding");

  a_clear_on_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && item_i.last |=> (pos_q == 2'd0) && (cnt_q == 3'd0) && (pad_q == 2'd0)
      && (err_q == b64d_pkg::ST_OK))
    else $error("state not cleared after the last character");

  a_residual_even: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q[0] == 1'b0) && (cnt_q <= 3'd6))
    else $error("residual bit count out of range");

endmodule
`default_nettype wire
